FILE: sv/cdsg_pkg.sv
// ----------------------------------------------------------------------------
// cdsg_pkg
// Shared constants for the codebook deskew segmenter: codebook count, code
// width, store geometry and stream word layout.
// ----------------------------------------------------------------------------
package cdsg_pkg;

	localparam int NUM_CODEBOOKS = 16;
	localparam int CODE_BITS     = 12;

	// fixed field widths
	localparam int CODE_W  = 12;
	localparam int CHOUT_W = 4;
	localparam int DATA_W  = 16;

	// channel / slot index width, store address width
	localparam int CH_W   = (NUM_CODEBOOKS > 1) ? $clog2(NUM_CODEBOOKS) : 1;
	localparam int ADDR_W = 2 * CH_W;
	localparam int DEPTH  = 1 << ADDR_W;

	localparam logic [CODE_W-1:0] CODE_MASK =
		(CODE_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((64'd1 << CODE_BITS) - 64'd1);

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CODEBOOKS - 1);

endpackage

FILE: sv/cdsg_ram.sv
// ----------------------------------------------------------------------------
// cdsg_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while not enabled. Old data on a same-address
// read and write.
// ----------------------------------------------------------------------------
module cdsg_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/codebook_deskew_segmenter_top.sv
// ----------------------------------------------------------------------------
// codebook_deskew_segmenter_top
// Deskews a delayed multi-codebook code stream and emits each completed
// non-pad frame in channel order, marking the start of each segment.
//
// channel   dir  signals                              contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser    delayed codes
// m_*       out  m_tvalid m_tready m_tdata m_tuser    deskewed frame codes
//                m_tlast
// cfg_*     in   cfg_valid cfg_ready cfg_data         pad code register
//
// One input word per cycle, except that input is held after the last word
// of a row that completes a kept frame until the frame's first entry is read.
// A kept frame drains from the frame store at one word per cycle through the
// store's read port, overlapped with the next row's input; the first word is
// read after the drain flag is set and leaves from the store's registered read.
// Input is held while a write would hit a not yet read entry of the draining
// frame (any word is taken as a possible stream start writing slot zero entry
// zero), or a row's last word arrives while a drain is still running.
// Reset clears counters, flags and the drain; the store needs no clearing.
// Output stalls hold the read port, and so the drain, in place.
// ----------------------------------------------------------------------------
module codebook_deskew_segmenter_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [cdsg_pkg::DATA_W-1:0] s_tdata,  // code_in [11:0], zeros
	input  logic                      s_tuser,    // stream_start
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [cdsg_pkg::DATA_W-1:0] m_tdata,  // code_out [11:0], channel_out [15:12]
	output logic                      m_tuser,    // segment_start
	output logic                      m_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cdsg_pkg::CODE_W-1:0] cfg_data
);

	import cdsg_pkg::*;

	logic [CODE_W-1:0]        pad_q;
	logic [CH_W-1:0]          ch_q;
	logic [CH_W-1:0]          row_q;
	logic [CH_W-1:0]          slot_q;
	logic                     prev_q;
	logic [NUM_CODEBOOKS-1:0] flags_q;

	logic                     busy_q;
	logic [CH_W:0]            rd_q;
	logic [CH_W-1:0]          dslot_q;
	logic                     seg_q;
	logic                     out_valid_q;
	logic [CH_W-1:0]          chan_q;
	logic                     last_q;
	logic                     seg_out_q;

	logic                     in_fire;
	logic                     rd_fire;
	logic                     start;
	logic [CH_W-1:0]          ch_n;
	logic [CH_W-1:0]          row_n;
	logic [CH_W-1:0]          slot_n;
	logic                     prev_n;
	logic [CH_W:0]            fs_sum;
	logic [CH_W-1:0]          fs;
	logic [CH_W:0]            fsq_sum;
	logic [CH_W-1:0]          fsq;
	logic [CH_W-1:0]          cs;
	logic [CODE_W-1:0]        code;
	logic                     nonpad;
	logic                     flag_new;
	logic                     row_end;
	logic                     complete;
	logic                     keep;
	logic                     hz_norm;
	logic                     hz_start;
	logic [CODE_W-1:0]        rdata;
	logic [CH_W+CHOUT_W-1:0]  chan_ext;
	logic                     unused_bits;

	assign cfg_ready = 1'b1;

	// current word, with a stream start clearing the counters first
	assign start  = s_tuser;
	assign ch_n   = start ? '0 : ch_q;
	assign row_n  = start ? '0 : row_q;
	assign slot_n = start ? '0 : slot_q;
	assign prev_n = start ? 1'b0 : prev_q;

	assign fs_sum = {1'b0, slot_n} + (CH_W+1)'(NUM_CODEBOOKS) - {1'b0, ch_n};
	assign fs     = ({1'b0, slot_n} >= {1'b0, ch_n}) ? (slot_n - ch_n) : fs_sum[CH_W-1:0];
	assign cs     = (slot_n == LAST_CH) ? '0 : (slot_n + 1'b1);

	assign code     = s_tdata[CODE_W-1:0] & CODE_MASK;
	assign nonpad   = (code != pad_q);
	assign flag_new = ((ch_n == '0) ? 1'b0 : flags_q[fs]) | nonpad;
	assign row_end  = (ch_n == LAST_CH);
	assign complete = row_end && (row_n == LAST_CH);
	assign keep     = complete && flag_new;

	// hold input off entries of the draining frame not yet read
	assign fsq_sum  = {1'b0, slot_q} + (CH_W+1)'(NUM_CODEBOOKS) - {1'b0, ch_q};
	assign fsq      = (slot_q >= ch_q) ? (slot_q - ch_q) : fsq_sum[CH_W-1:0];
	assign hz_norm  = (fsq == dslot_q) && ({1'b0, ch_q} >= rd_q);
	assign hz_start = (dslot_q == '0) && (rd_q == '0);
	assign s_tready = !busy_q || !(hz_norm || hz_start || (ch_q == LAST_CH));

	assign in_fire = s_tvalid && s_tready;
	assign rd_fire = busy_q && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			pad_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q    <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			prev_q  <= 1'b0;
			flags_q <= '0;
		end else if (in_fire) begin
			flags_q[fs] <= flag_new;
			if (row_end) begin
				ch_q   <= '0;
				row_q  <= (row_n == LAST_CH) ? row_n : (row_n + 1'b1);
				slot_q <= cs;
				prev_q <= complete ? flag_new : prev_n;
			end else begin
				ch_q   <= ch_n + 1'b1;
				row_q  <= row_n;
				slot_q <= slot_n;
				prev_q <= prev_n;
			end
		end
	end

	// drain of a kept frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			rd_q    <= '0;
			dslot_q <= '0;
			seg_q   <= 1'b0;
		end else if (in_fire && keep) begin
			busy_q  <= 1'b1;
			rd_q    <= '0;
			dslot_q <= cs;
			seg_q   <= !prev_n;
		end else if (rd_fire) begin
			rd_q <= rd_q + 1'b1;
			if (rd_q == {1'b0, LAST_CH}) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_fire) begin
			chan_q    <= rd_q[CH_W-1:0];
			last_q    <= (rd_q == {1'b0, LAST_CH});
			seg_out_q <= seg_q;
		end
	end

	cdsg_ram #(
		.WIDTH (CODE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (in_fire),
		.waddr ({fs, ch_n}),
		.wdata (code),
		.re    (rd_fire),
		.raddr ({dslot_q, rd_q[CH_W-1:0]}),
		.rdata (rdata)
	);

	assign chan_ext = {{CHOUT_W{1'b0}}, chan_q};
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {chan_ext[CHOUT_W-1:0], rdata};
	assign m_tuser  = seg_out_q;
	assign m_tlast  = last_q;

	// unused upper pad bits of the input word
	assign unused_bits = ^s_tdata[DATA_W-1:CODE_W];

endmodule
